// ===== hdl/rnss_pkg.sv =====
// ----------------------------------------------------------------------------
// rnss_pkg
// Shared types, constants and lookup functions for the radix number to
// seven-segment display block.
// ----------------------------------------------------------------------------
package rnss_pkg;

  // Payload widths fixed by the interface.
  localparam int unsigned NUMBER_W  = 32;
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned PATTERN_W = 8;
  localparam int unsigned POS_COUNT = 5;

  // Any magnitude that can be shown fits in this many bits (16^4 - 1).
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned DIGIT_W     = 4;
  // The divider retires this many quotient bits per cycle.
  localparam int unsigned STEP_BITS   = 4;
  localparam int unsigned STEP_COUNT  = MAG_W / STEP_BITS;
  localparam int unsigned STEP_CNT_W  = $clog2(STEP_COUNT);

  localparam logic [RADIX_W-1:0]   RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0]   RADIX_MAX  = 5'd16;
  localparam logic [2:0]           DIGITS_POS = 3'd4;
  localparam logic [2:0]           DIGITS_NEG = 3'd3;
  localparam logic [PATTERN_W-1:0] SEG_MINUS  = 8'h40;
  localparam logic [PATTERN_W-1:0] SEG_BLANK  = 8'h00;

  typedef struct packed {
    logic signed [NUMBER_W-1:0] number;
    logic        [RADIX_W-1:0]  radix;
  } in_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_pos0;
    logic [PATTERN_W-1:0] pattern_pos1;
    logic [PATTERN_W-1:0] pattern_pos2;
    logic [PATTERN_W-1:0] pattern_pos3;
    logic [PATTERN_W-1:0] pattern_pos4;
    logic                 overflow_error;
  } out_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic               start;
    logic [MAG_W-1:0]   dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  // Result from the divider, valid while done is high.
  typedef struct packed {
    logic               done;
    logic [MAG_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_e;

  // Hexadecimal seven-segment table, bit0 top through bit6 center.
  function automatic logic [PATTERN_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [PATTERN_W-1:0] seg;
    unique case (digit)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  // Display position of the n-th digit, least significant first.
  function automatic logic [2:0] digit_slot(input logic [1:0] idx);
    logic [2:0] slot;
    unique case (idx)
      2'd0: slot = 3'd4;
      2'd1: slot = 3'd3;
      2'd2: slot = 3'd1;
      2'd3: slot = 3'd0;
      default: slot = 3'd4;
    endcase
    return slot;
  endfunction

endpackage

// ===== hdl/rnss_divider.sv =====
// ----------------------------------------------------------------------------
// rnss_divider
// Iterative restoring divider: a 16-bit dividend by a 5-bit divisor, four
// quotient bits per cycle, result flagged by a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rnss_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rnss_pkg::div_req_t req_i,
  output rnss_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [rnss_pkg::STEP_CNT_W-1:0]     cnt_q, cnt_d;
  logic [rnss_pkg::MAG_W-1:0]          quo_q, quo_d;
  logic [rnss_pkg::DIGIT_W-1:0]        rem_q, rem_d;
  logic [rnss_pkg::RADIX_W-1:0]        div_q, div_d;

  logic [rnss_pkg::MAG_W-1:0]          step_quo;
  logic [rnss_pkg::DIGIT_W-1:0]        step_rem;

  // Four restoring steps: the partial remainder stays below the divisor,
  // so it never needs more than four bits between steps.
  always_comb begin
    logic [rnss_pkg::DIGIT_W:0]   part;
    logic [rnss_pkg::MAG_W-1:0]   q;
    logic [rnss_pkg::DIGIT_W-1:0] r;
    q = quo_q;
    r = rem_q;
    for (int i = 0; i < int'(rnss_pkg::STEP_BITS); i++) begin
      part = {r, q[rnss_pkg::MAG_W-1]};
      q    = {q[rnss_pkg::MAG_W-2:0], 1'b0};
      if (part >= div_q) begin
        part = part - div_q;
        q[0] = 1'b1;
      end
      r = part[rnss_pkg::DIGIT_W-1:0];
    end
    step_quo = q;
    step_rem = r;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = step_quo;
      rem_d = step_rem;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rnss_pkg::STEP_CNT_W'(rnss_pkg::STEP_COUNT - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== hdl/radix_number_to_seven_segment.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_seven_segment
// Converts a signed 32-bit number to seven-segment patterns for a
// five-position display in a radix from 2 to 16.
// ----------------------------------------------------------------------------
// Sequence: zero, a bad radix or an obvious overflow goes from idle straight
// to the output state; otherwise one division runs per digit, up to 4 digits.
// Throughput: one transaction at a time; the next is taken the cycle after
// the result transaction completes. The shared divider, which works out one
// digit per division, sets the pace.
// Reset: asynchronous, active low; the block returns to idle with no result.
// ----------------------------------------------------------------------------
module radix_number_to_seven_segment (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rnss_pkg::in_t in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rnss_pkg::out_t out_o
);

  rnss_pkg::state_e state_q, state_d;

  // Sequencer registers. The count is the number of digits drawn so far.
  logic [2:0]                      count_q, count_d;
  logic                            neg_q, neg_d;
  logic                            err_q, err_d;
  logic [rnss_pkg::RADIX_W-1:0]    radix_q, radix_d;
  logic [rnss_pkg::PATTERN_W-1:0]  pat_q [rnss_pkg::POS_COUNT];
  logic [rnss_pkg::PATTERN_W-1:0]  pat_d [rnss_pkg::POS_COUNT];

  rnss_pkg::div_req_t div_req;
  rnss_pkg::div_rsp_t div_rsp;

  logic                             in_accept;
  logic [rnss_pkg::NUMBER_W-1:0]    raw;
  logic                             neg_in;
  logic [rnss_pkg::NUMBER_W-1:0]    mag_in;
  logic                             radix_bad;
  logic                             early_err;
  logic                             early_zero;
  logic [2:0]                       count_next;
  logic [2:0]                       digit_limit;
  logic                             quot_zero;
  logic                             digits_full;

  // The input transaction is taken only in idle; a result waiting in the
  // output stage holds the input side off until it has been delivered.
  assign in_accept = in_valid_i && !in_stall_o;

  // Sign and magnitude of the incoming number. The magnitude of the most
  // negative number comes out as 2^31, which the early check rejects.
  assign raw    = rnss_pkg::NUMBER_W'(in_i.number);
  assign neg_in = raw[rnss_pkg::NUMBER_W-1];
  assign mag_in = neg_in ? (rnss_pkg::NUMBER_W'(0) - raw) : raw;

  assign radix_bad = (in_i.radix < rnss_pkg::RADIX_MIN) || (in_i.radix > rnss_pkg::RADIX_MAX);

  // Every displayable magnitude is below 16^4, so anything with upper bits
  // set overflows whatever the radix. Smaller values are settled digit by
  // digit: a quotient still nonzero after the last digit slot is an overflow.
  assign early_err  = radix_bad || (mag_in[rnss_pkg::NUMBER_W-1:rnss_pkg::MAG_W] != '0);
  assign early_zero = (mag_in == '0);

  assign count_next  = count_q + 3'd1;
  assign digit_limit = neg_q ? rnss_pkg::DIGITS_NEG : rnss_pkg::DIGITS_POS;
  assign quot_zero   = (div_rsp.quotient == '0);
  assign digits_full = (count_next == digit_limit);

  rnss_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rnss_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (early_err || early_zero) begin
            state_d = rnss_pkg::ST_OUTPUT;
          end else begin
            state_d = rnss_pkg::ST_DIVIDE;
          end
        end
      end
      rnss_pkg::ST_DIVIDE: begin
        if (div_rsp.done && (quot_zero || digits_full)) begin
          state_d = rnss_pkg::ST_OUTPUT;
        end
      end
      rnss_pkg::ST_OUTPUT: begin
        if (!out_stall_i) begin
          state_d = rnss_pkg::ST_IDLE;
        end
      end
      default: state_d = rnss_pkg::ST_IDLE;
    endcase
  end

  // Datapath and divider control.
  always_comb begin
    count_d = count_q;
    neg_d   = neg_q;
    err_d   = err_q;
    radix_d = radix_q;
    pat_d   = pat_q;
    div_req = '0;

    unique case (state_q)
      rnss_pkg::ST_IDLE: begin
        if (in_accept) begin
          count_d = '0;
          neg_d   = neg_in;
          radix_d = in_i.radix;
          err_d   = 1'b0;
          for (int i = 0; i < int'(rnss_pkg::POS_COUNT); i++) begin
            pat_d[i] = rnss_pkg::SEG_BLANK;
          end
          if (early_err) begin
            err_d = 1'b1;
            for (int i = 0; i < int'(rnss_pkg::POS_COUNT); i++) begin
              pat_d[i] = rnss_pkg::SEG_MINUS;
            end
            pat_d[2] = rnss_pkg::SEG_BLANK;
          end else if (!early_zero) begin
            div_req.start    = 1'b1;
            div_req.dividend = mag_in[rnss_pkg::MAG_W-1:0];
            div_req.divisor  = in_i.radix;
          end
        end
      end
      rnss_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          // The remainder is the next digit; the quotient carries on.
          pat_d[rnss_pkg::digit_slot(count_q[1:0])] = rnss_pkg::seg_pattern(div_rsp.remainder);
          count_d = count_next;
          if (quot_zero) begin
            // A negative value never uses more than three digits, so the
            // sign always finds a free slot left of the top digit.
            if (neg_q) begin
              pat_d[rnss_pkg::digit_slot(count_next[1:0])] = rnss_pkg::SEG_MINUS;
            end
          end else if (digits_full) begin
            err_d = 1'b1;
            for (int i = 0; i < int'(rnss_pkg::POS_COUNT); i++) begin
              pat_d[i] = rnss_pkg::SEG_MINUS;
            end
            pat_d[2] = rnss_pkg::SEG_BLANK;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = radix_q;
          end
        end
      end
      rnss_pkg::ST_OUTPUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rnss_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    err_q   <= err_d;
    radix_q <= radix_d;
    pat_q   <= pat_d;
  end

  assign in_stall_o  = (state_q != rnss_pkg::ST_IDLE);
  assign out_valid_o = (state_q == rnss_pkg::ST_OUTPUT);

  assign out_o.pattern_pos0   = pat_q[0];
  assign out_o.pattern_pos1   = pat_q[1];
  assign out_o.pattern_pos2   = pat_q[2];
  assign out_o.pattern_pos3   = pat_q[3];
  assign out_o.pattern_pos4   = pat_q[4];
  assign out_o.overflow_error = err_q;

endmodule
